// ===== rtl/tlag_pkg.sv =====
// Shared types, constants and codes for the tensor layout address generator.
// No dependencies; every other file but tlag_div_step imports this package.
package tlag_pkg;

    // Fixed geometry of the configuration registers
    localparam int SLOTS      = 4;
    localparam int MAX_RANK   = 4;
    localparam int INDEX_BITS = 32;
    localparam int DIM_BITS   = 16;
    localparam int DIM_W      = 16;
    localparam int IDX_W      = 32;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [DIM_W-1:0] DIM_MASK = DIM_W'((32'd1 << DIM_BITS) - 32'd1);
    localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= 32) ? 32'hFFFF_FFFF :
                                            32'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic [64:0] COUNT_LIMIT = 65'd1 << INDEX_BITS;

    // Mode codes
    localparam logic [2:0] MODE_IDENTITY  = 3'd0;
    localparam logic [2:0] MODE_TRANSPOSE = 3'd1;
    localparam logic [2:0] MODE_REVERSE   = 3'd2;
    localparam logic [2:0] MODE_SLICE     = 3'd3;
    localparam logic [2:0] MODE_TILE      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_CFG = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REV     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd6;

    // Configuration as seen by the datapath, raw and derived
    typedef struct packed {
        logic [2:0]                       mode;
        logic [2:0]                       rank;
        logic [SLOTS-1:0][1:0]            perm;
        logic [1:0]                       rev;
        logic [SLOTS-1:0][DIM_W-1:0]      start;
        logic [SLOTS-1:0][DIM_W-1:0]      src_dim;
        logic [SLOTS-1:0][DIM_W-1:0]      res_eff;
        logic [SLOTS-1:0][IDX_W-1:0]      stride;
        logic [63:0]                      res_count;
        logic                             ok;
    } t_cfg_view;

    // Payload carried through the unflatten chain
    typedef struct packed {
        logic [IDX_W-1:0]                 idx;
        logic [SLOTS-1:0][DIM_W-1:0]      coord;
    } t_coord_pay;

    // Coordinates leaving the divider chains
    typedef struct packed {
        logic [IDX_W-1:0]                 idx;
        logic [SLOTS-1:0][DIM_W-1:0]      coord;
        logic [SLOTS-1:0][DIM_W-1:0]      tmod;
    } t_coord_res;

endpackage

// ===== rtl/tlag_div_step.sv =====
// One registered restoring-division step over several lanes, with payload.
// Generic; no package dependency.
module tlag_div_step #(
    parameter int LANES = 1,
    parameter int NUM_W = 32,
    parameter int DIV_W = 16,
    parameter int PAY_W = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]       i_num,
    input  logic [LANES-1:0][DIV_W-1:0]       i_rem,
    input  logic [LANES-1:0][DIV_W-1:0]       i_div,
    input  logic [PAY_W-1:0]                  i_pay,
    output logic                              o_valid,
    output logic [LANES-1:0][NUM_W-1:0]       o_num,
    output logic [LANES-1:0][DIV_W-1:0]       o_rem,
    output logic [PAY_W-1:0]                  o_pay
);

    logic                        r_valid;
    logic [LANES-1:0][NUM_W-1:0] r_num, n_num;
    logic [LANES-1:0][DIV_W-1:0] r_rem, n_rem;
    logic [PAY_W-1:0]            r_pay;
    logic [DIV_W:0]              t;
    logic                        ge;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        t  = '0;
        ge = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            t        = {i_rem[l], i_num[l][NUM_W-1]};
            ge       = (t >= {1'b0, i_div[l]});
            n_rem[l] = ge ? DIV_W'(t - {1'b0, i_div[l]}) : t[DIV_W-1:0];
            n_num[l] = {i_num[l][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_pay   = r_pay;

endmodule

// ===== rtl/tlag_cfg.sv =====
// Configuration registers, derived strides and counts, and validity checks.
// Depends on tlag_pkg.
module tlag_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tlag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tlag_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tlag_pkg::t_cfg_view              o_cfg
);
    import tlag_pkg::*;

    logic [2:0]  r_mode, r_rank;
    logic [63:0] r_src_shape, r_res_shape, r_start;
    logic [7:0]  r_perm;
    logic [1:0]  r_rev;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDENTITY;
            r_rank      <= 3'd1;
            r_src_shape <= 64'h0001_0001_0001_0001;
            r_res_shape <= 64'h0001_0001_0001_0001;
            r_perm      <= 8'hE4;
            r_rev       <= 2'd0;
            r_start     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode      <= i_cfg_data[2:0];
                REG_RANK:  r_rank      <= i_cfg_data[2:0];
                REG_SRC:   r_src_shape <= i_cfg_data;
                REG_RES:   r_res_shape <= i_cfg_data;
                REG_PERM:  r_perm      <= i_cfg_data[7:0];
                REG_REV:   r_rev       <= i_cfg_data[1:0];
                REG_START: r_start     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-axis views; unused axes count as size one
    logic [SLOTS-1:0][DIM_W-1:0] dim_s, dim_r, start_k, eff_s, eff_r;
    logic [SLOTS-1:0][1:0]       perm_k;
    logic [SLOTS-1:0]            used;

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            dim_s[k]   = r_src_shape[16*k +: 16] & DIM_MASK;
            dim_r[k]   = r_res_shape[16*k +: 16] & DIM_MASK;
            start_k[k] = r_start[16*k +: 16] & DIM_MASK;
            perm_k[k]  = r_perm[2*k +: 2];
            used[k]    = (3'(k) < r_rank);
            eff_s[k]   = used[k] ? dim_s[k] : DIM_W'(1);
            eff_r[k]   = used[k] ? dim_r[k] : DIM_W'(1);
        end
    end

    // cheap checks
    logic       rank_ok, perm_ok, rev_ok, slice_ok;
    logic [3:0] seen;

    always_comb begin
        rank_ok  = (r_rank >= 3'd1) && (r_rank <= 3'(MAX_RANK)) && (r_rank <= 3'(SLOTS));
        perm_ok  = 1'b1;
        rev_ok   = ({1'b0, r_rev} < r_rank);
        slice_ok = 1'b1;
        seen     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (used[i]) begin
                if ((3'(perm_k[i]) >= r_rank) || seen[perm_k[i]]) begin
                    perm_ok = 1'b0;
                end
                seen[perm_k[i]] = 1'b1;
                if (dim_s[i] != dim_r[i]) begin
                    rev_ok = 1'b0;
                end
                if (({1'b0, start_k[i]} + {1'b0, dim_r[i]}) > {1'b0, dim_s[i]}) begin
                    slice_ok = 1'b0;
                end
            end
        end
    end

    // tile check: bit-serial remainder of result size by source size, axis by axis
    logic [6:0]       r_tc_cnt;
    logic [DIM_W-1:0] r_tc_rem, n_tc_rem;
    logic             r_tile_ok, tc_cond;
    logic [1:0]       tc_ax;
    logic [3:0]       tc_bit;
    logic [DIM_W:0]   tc_t;
    logic             tc_ge;

    always_comb begin
        tc_ax    = r_tc_cnt[5:4];
        tc_bit   = r_tc_cnt[3:0];
        tc_t     = {((tc_bit == 4'd0) ? {DIM_W{1'b0}} : r_tc_rem), dim_r[tc_ax][~tc_bit]};
        tc_ge    = (tc_t >= {1'b0, dim_s[tc_ax]});
        n_tc_rem = tc_ge ? DIM_W'(tc_t - {1'b0, dim_s[tc_ax]}) : tc_t[DIM_W-1:0];
        if (dim_s[tc_ax] == '0) begin
            tc_cond = (dim_r[tc_ax] == '0);
        end else begin
            tc_cond = (dim_r[tc_ax] >= dim_s[tc_ax]) && (n_tc_rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc_cnt  <= '0;
            r_tile_ok <= 1'b1;
        end else if (i_cfg_we) begin
            r_tc_cnt  <= '0;
            r_tile_ok <= 1'b1;
        end else if (!r_tc_cnt[6]) begin
            r_tc_cnt <= r_tc_cnt + 7'd1;
            if ((tc_bit == 4'hF) && used[tc_ax] && !tc_cond) begin
                r_tile_ok <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tc_rem <= n_tc_rem;
    end

    // derived products, two multiply stages then the final verdict
    logic [31:0] r_ps01, r_ps23, r_pr01, r_pr23, r_str0;
    logic [63:0] r_cnt_s, r_cnt_r;
    logic        r_rank_ok, r_perm_ok, r_rev_ok, r_slice_ok, r_ok, n_ok;

    always_ff @(posedge i_clk) begin
        r_ps01     <= eff_s[0] * eff_s[1];
        r_ps23     <= eff_s[2] * eff_s[3];
        r_pr01     <= eff_r[0] * eff_r[1];
        r_pr23     <= eff_r[2] * eff_r[3];
        r_rank_ok  <= rank_ok;
        r_perm_ok  <= perm_ok;
        r_rev_ok   <= rev_ok;
        r_slice_ok <= slice_ok;
        r_cnt_s    <= r_ps01 * r_ps23;
        r_cnt_r    <= r_pr01 * r_pr23;
        r_str0     <= 32'(r_ps23 * eff_s[1]);
        r_ok       <= n_ok;
    end

    always_comb begin
        unique case (r_mode)
            MODE_IDENTITY:  n_ok = (r_cnt_s == r_cnt_r);
            MODE_TRANSPOSE: n_ok = r_perm_ok;
            MODE_REVERSE:   n_ok = r_rev_ok;
            MODE_SLICE:     n_ok = r_slice_ok;
            MODE_TILE:      n_ok = r_tile_ok;
            default:        n_ok = 1'b0;
        endcase
        n_ok = n_ok && r_rank_ok && ({1'b0, r_cnt_s} <= COUNT_LIMIT)
                    && ({1'b0, r_cnt_r} <= COUNT_LIMIT);
    end

    always_comb begin
        o_cfg.mode      = r_mode;
        o_cfg.rank      = r_rank;
        o_cfg.perm      = perm_k;
        o_cfg.rev       = r_rev;
        o_cfg.start     = start_k;
        o_cfg.src_dim   = dim_s;
        o_cfg.res_eff   = eff_r;
        o_cfg.stride[3] = 32'd1;
        o_cfg.stride[2] = {16'd0, eff_s[3]};
        o_cfg.stride[1] = r_ps23;
        o_cfg.stride[0] = r_str0;
        o_cfg.res_count = r_cnt_r;
        o_cfg.ok        = r_ok;
    end

endmodule

// ===== rtl/tlag_coord.sv =====
// Divider pipeline: unflattens the result index into coordinates, then the
// per-axis remainder by the source size for tile mode. Uses tlag_div_step, tlag_pkg.
module tlag_coord (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [31:0]              i_index,
    input  tlag_pkg::t_cfg_view      i_cfg,
    output logic                     o_valid,
    output tlag_pkg::t_coord_res     o_res
);
    import tlag_pkg::*;

    localparam int USTEPS = SLOTS * IDX_W;
    localparam int PAY_W  = $bits(t_coord_pay);

    // entry register
    logic             r_in_valid;
    logic [IDX_W-1:0] r_in_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_idx <= i_index;
        end
    end

    // unflatten chain, innermost axis first, one quotient bit per stage
    logic             u_valid [0:USTEPS];
    logic [IDX_W-1:0] u_num   [0:USTEPS];
    logic [DIM_W-1:0] u_rem   [0:USTEPS];
    t_coord_pay       u_pay   [0:USTEPS];

    assign u_valid[0]     = r_in_valid;
    assign u_num[0]       = r_in_idx;
    assign u_rem[0]       = '0;
    assign u_pay[0].idx   = r_in_idx;
    assign u_pay[0].coord = '0;

    for (genvar j = 0; j < USTEPS; j++) begin : g_unflat
        localparam int AX = SLOTS - 1 - j / IDX_W;
        logic [IDX_W-1:0] s_num;
        logic [DIM_W-1:0] s_rem;
        t_coord_pay       s_pay;

        if ((j % IDX_W == 0) && (j != 0)) begin : g_axis_edge
            // previous axis done: keep its remainder, restart on the quotient
            always_comb begin
                s_pay           = u_pay[j];
                s_pay.coord[AX+1] = u_rem[j];
                s_num           = u_num[j];
                s_rem           = '0;
            end
        end else begin : g_mid
            assign s_pay = u_pay[j];
            assign s_num = u_num[j];
            assign s_rem = u_rem[j];
        end

        tlag_div_step #(
            .LANES(1), .NUM_W(IDX_W), .DIV_W(DIM_W), .PAY_W(PAY_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (u_valid[j]),
            .i_num   (s_num),
            .i_rem   (s_rem),
            .i_div   (i_cfg.res_eff[AX]),
            .i_pay   (s_pay),
            .o_valid (u_valid[j+1]),
            .o_num   (u_num[j+1]),
            .o_rem   (u_rem[j+1]),
            .o_pay   (u_pay[j+1])
        );
    end

    // tile remainder chain, all axes side by side
    logic                        m_valid [0:DIM_W];
    logic [SLOTS-1:0][DIM_W-1:0] m_num   [0:DIM_W];
    logic [SLOTS-1:0][DIM_W-1:0] m_rem   [0:DIM_W];
    t_coord_pay                  m_pay   [0:DIM_W];

    always_comb begin
        m_pay[0]          = u_pay[USTEPS];
        m_pay[0].coord[0] = u_rem[USTEPS];
    end
    assign m_valid[0] = u_valid[USTEPS];
    assign m_num[0]   = m_pay[0].coord;
    assign m_rem[0]   = '0;

    for (genvar j = 0; j < DIM_W; j++) begin : g_tile
        tlag_div_step #(
            .LANES(SLOTS), .NUM_W(DIM_W), .DIV_W(DIM_W), .PAY_W(PAY_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (m_valid[j]),
            .i_num   (m_num[j]),
            .i_rem   (m_rem[j]),
            .i_div   (i_cfg.src_dim),
            .i_pay   (m_pay[j]),
            .o_valid (m_valid[j+1]),
            .o_num   (m_num[j+1]),
            .o_rem   (m_rem[j+1]),
            .o_pay   (m_pay[j+1])
        );
    end

    assign o_valid     = m_valid[DIM_W];
    assign o_res.idx   = m_pay[DIM_W].idx;
    assign o_res.coord = m_pay[DIM_W].coord;
    assign o_res.tmod  = m_rem[DIM_W];

endmodule

// ===== rtl/tlag_flat.sv =====
// Per-mode coordinate mapping, stride products and the final flat sum.
// Depends on tlag_pkg.
module tlag_flat (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  tlag_pkg::t_coord_res     i_res,
    input  tlag_pkg::t_cfg_view      i_cfg,
    output logic                     o_valid,
    output logic [31:0]              o_idx,
    output logic [31:0]              o_flat
);
    import tlag_pkg::*;

    logic [SLOTS-1:0][DIM_W:0]   n_src, r_m_src;
    logic [SLOTS-1:0][IDX_W-1:0] r_p_prod;
    logic [IDX_W-1:0]            r_m_idx, r_p_idx, r_s_idx, r_s_flat;
    logic                        r_m_valid, r_p_valid, r_s_valid;

    // map result coordinates to source coordinates
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            n_src[k] = {1'b0, i_res.coord[k]};
        end
        unique case (i_cfg.mode)
            MODE_TRANSPOSE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (3'(i) < i_cfg.rank) begin
                        n_src[i_cfg.perm[i]] = {1'b0, i_res.coord[i]};
                    end
                end
            end
            MODE_REVERSE: begin
                n_src[i_cfg.rev] = {1'b0, i_cfg.src_dim[i_cfg.rev] - DIM_W'(1)
                                          - i_res.coord[i_cfg.rev]};
            end
            MODE_SLICE: begin
                for (int k = 0; k < SLOTS; k++) begin
                    n_src[k] = {1'b0, i_res.coord[k]} + {1'b0, i_cfg.start[k]};
                end
            end
            MODE_TILE: begin
                for (int k = 0; k < SLOTS; k++) begin
                    n_src[k] = {1'b0, i_res.tmod[k]};
                end
            end
            default: ;
        endcase
        for (int k = 0; k < SLOTS; k++) begin
            if (!(3'(k) < i_cfg.rank)) begin
                n_src[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
            r_p_valid <= r_m_valid;
            r_s_valid <= r_p_valid;
        end
    end

    // map, multiply and sum stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_src <= n_src;
            r_m_idx <= i_res.idx;
            for (int k = 0; k < SLOTS; k++) begin
                r_p_prod[k] <= 32'(r_m_src[k] * i_cfg.stride[k]);
            end
            r_p_idx  <= r_m_idx;
            r_s_flat <= r_p_prod[0] + r_p_prod[1] + r_p_prod[2] + r_p_prod[3];
            r_s_idx  <= r_p_idx;
        end
    end

    assign o_valid = r_s_valid;
    assign o_idx   = r_s_idx;
    assign o_flat  = r_s_flat;

endmodule

// ===== rtl/tensor_layout_address_generator.sv =====
// Top level of the tensor layout address generator: stream in, stream out.
// Depends on tlag_pkg, tlag_cfg, tlag_coord, tlag_flat.
//
//  Channel   Port group             Payload
//  -------   --------------------   ---------------------------------------
//  input     i_s_tvalid/o_s_tready  tdata[31:0] result_index
//  output    o_m_tvalid/i_m_tready  tdata[31:0] source_index, tuser[1:0] status
//  config    i_cfg_we               i_cfg_index, i_cfg_data (64 bits)
//
// One request enters per cycle unless the output stalls; it passes the
// entry register, the divider chain (32 steps for each of four axes, 16
// for the tile remainder) and the map, multiply, sum and output registers.
// Synchronous active-low reset empties the pipeline and restores the
// register defaults. A stall on the output freezes every stage at once.
module tensor_layout_address_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [31:0]                      i_s_tdata,   // [31:0] result_index
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [31:0]                      o_m_tdata,   // [31:0] source_index
    output logic [tlag_pkg::STAT_W-1:0]      o_m_tuser,   // [1:0] status
    input  logic                             i_cfg_we,
    input  logic [tlag_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tlag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tlag_pkg::*;

    t_cfg_view        cfg;
    t_coord_res       coord_res;
    logic             coord_valid, flat_valid, en;
    logic [IDX_W-1:0] flat_idx, flat_val;

    // whole pipeline advances unless the output request is held
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index, n_out_index;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    tlag_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tlag_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_index (i_s_tdata),
        .i_cfg   (cfg),
        .o_valid (coord_valid),
        .o_res   (coord_res)
    );

    tlag_flat u_flat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (coord_valid),
        .i_res   (coord_res),
        .i_cfg   (cfg),
        .o_valid (flat_valid),
        .o_idx   (flat_idx),
        .o_flat  (flat_val)
    );

    // status and final index
    always_comb begin
        if (!cfg.ok) begin
            n_out_status = STAT_BAD_CFG;
        end else if ({32'd0, flat_idx} >= cfg.res_count) begin
            n_out_status = STAT_RANGE;
        end else begin
            n_out_status = STAT_OK;
        end
        if (n_out_status != STAT_OK) begin
            n_out_index = '0;
        end else if (cfg.mode == MODE_IDENTITY) begin
            n_out_index = flat_idx & IDX_MASK;
        end else begin
            n_out_index = flat_val & IDX_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= flat_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_index  <= n_out_index;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_index;
    assign o_m_tuser  = r_out_status;

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the tensor layout address generator.
// Depends on tlag_pkg and the top level tensor_layout_address_generator.
`timescale 1ns / 1ps
module testbench;
    import tlag_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;    // [31:0] result_index
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;    // [31:0] source_index
    logic [1:0]  o_m_tuser;    // [1:0] status
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    typedef struct packed {
        logic [31:0] src_idx;
        logic [1:0]  status;
    } t_answer;

    // Shadow of the configuration registers
    logic [2:0]  sh_mode;
    logic [2:0]  sh_rank;
    logic [63:0] sh_src;
    logic [63:0] sh_res;
    logic [7:0]  sh_perm;
    logic [1:0]  sh_rev;
    logic [63:0] sh_start;

    logic [31:0] index_queue[$];
    t_answer     answer_queue[$];
    int          n_errors;
    int          n_accepted;
    int          n_checked;
    int          n_status[3];
    int          n_phases;
    int          cycle_count;
    logic        quiet;
    logic        hold_go;
    logic        hold_done;
    int          in_gap;
    int          out_gap;

    tensor_layout_address_generator uut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] dim_of(input logic [63:0] shape, input int i);
        return {48'd0, shape[16*i +: 16]};
    endfunction

    function automatic logic [63:0] elem_count(input logic [63:0] shape, input int r);
        logic [63:0] n;
        n = 64'd1;
        for (int i = 0; i < r; i++) n = n * dim_of(shape, i);
        return n;
    endfunction

    // Configuration checks as the block performs them
    function automatic logic config_valid();
        int          r;
        logic [3:0]  seen;
        logic [63:0] s;
        logic [63:0] o;
        r = sh_rank;
        if (sh_rank < 1 || sh_rank > MAX_RANK) return 1'b0;
        if (elem_count(sh_src, r) > 64'h1_0000_0000) return 1'b0;
        if (elem_count(sh_res, r) > 64'h1_0000_0000) return 1'b0;
        case (sh_mode)
            MODE_IDENTITY: return elem_count(sh_src, r) == elem_count(sh_res, r);
            MODE_TRANSPOSE: begin
                seen = 4'd0;
                for (int i = 0; i < r; i++) begin
                    if (sh_perm[2*i +: 2] >= r || seen[sh_perm[2*i +: 2]]) return 1'b0;
                    seen[sh_perm[2*i +: 2]] = 1'b1;
                end
                return 1'b1;
            end
            MODE_REVERSE: begin
                for (int i = 0; i < r; i++)
                    if (dim_of(sh_src, i) != dim_of(sh_res, i)) return 1'b0;
                return sh_rev < r;
            end
            MODE_SLICE: begin
                for (int i = 0; i < r; i++)
                    if (dim_of(sh_start, i) + dim_of(sh_res, i) > dim_of(sh_src, i))
                        return 1'b0;
                return 1'b1;
            end
            MODE_TILE: begin
                for (int i = 0; i < r; i++) begin
                    s = dim_of(sh_src, i);
                    o = dim_of(sh_res, i);
                    if (s == 0) begin
                        if (o != 0) return 1'b0;
                    end else if (o < s || (o % s) != 0) begin
                        return 1'b0;
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Expected answer for one result index under the shadow configuration
    function automatic t_answer source_of(input logic [31:0] idx);
        t_answer     a;
        logic [63:0] coord[4];
        logic [63:0] sc[4];
        logic [63:0] rem;
        logic [63:0] stride;
        logic [63:0] flat;
        int          r;
        int          ax;
        a.src_idx = 32'd0;
        a.status  = STAT_OK;
        if (!config_valid()) begin
            a.status = STAT_BAD_CFG;
            return a;
        end
        r = sh_rank;
        if ({32'd0, idx} >= elem_count(sh_res, r)) begin
            a.status = STAT_RANGE;
            return a;
        end
        rem = {32'd0, idx};
        for (int k = r - 1; k >= 0; k--) begin
            coord[k] = rem % dim_of(sh_res, k);
            rem      = rem / dim_of(sh_res, k);
        end
        for (int i = 0; i < r; i++) sc[i] = coord[i];
        case (sh_mode)
            MODE_TRANSPOSE: for (int i = 0; i < r; i++) sc[sh_perm[2*i +: 2]] = coord[i];
            MODE_REVERSE: begin
                ax = sh_rev;
                sc[ax] = dim_of(sh_src, ax) - 64'd1 - coord[ax];
            end
            MODE_SLICE: for (int i = 0; i < r; i++) sc[i] = coord[i] + dim_of(sh_start, i);
            MODE_TILE:  for (int i = 0; i < r; i++) sc[i] = coord[i] % dim_of(sh_src, i);
            default: ;
        endcase
        if (sh_mode == MODE_IDENTITY) begin
            flat = {32'd0, idx};
        end else begin
            flat   = 64'd0;
            stride = 64'd1;
            for (int k = r - 1; k >= 0; k--) begin
                flat   = flat + sc[k] * stride;
                stride = stride * dim_of(sh_src, k);
            end
        end
        a.src_idx = flat[31:0];
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        n_errors++;
    endtask

    // Append one index to the pending queue
    task automatic add_index(input logic [31:0] v);
        index_queue.insert(index_queue.size(), v);
    endtask

    // Request driver: feeds queued indices, idles in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                answer_queue.insert(answer_queue.size(), source_of(i_s_tdata));
                n_accepted++;
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the pending request
            end else if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (index_queue.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= index_queue.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
                if (!quiet && index_queue.size() > 0) in_gap <= $urandom_range(0, 15);
            end
        end
    end

    // Result monitor and receiver back-pressure, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            out_gap    <= 0;
            hold_done  <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (answer_queue.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, 32'd0);
                end else begin
                    t_answer w;
                    w = answer_queue.pop_front();
                    if (o_m_tdata !== w.src_idx)
                        report_mismatch("source_index", o_m_tdata, w.src_idx);
                    if (o_m_tuser !== w.status)
                        report_mismatch("status", {30'd0, o_m_tuser}, {30'd0, w.status});
                    if (w.status <= STAT_RANGE) n_status[w.status]++;
                    n_checked++;
                end
            end
            if (hold_go && !hold_done) begin
                hold_done  <= 1'b1;
                out_gap    <= 600;
                i_m_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap    <= out_gap - 1;
                i_m_tready <= 1'b0;
            end else if (quiet || $urandom_range(0, 5) != 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                out_gap    <= $urandom_range(0, 15);
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_MODE:  sh_mode  = val[2:0];
            REG_RANK:  sh_rank  = val[2:0];
            REG_SRC:   sh_src   = val;
            REG_RES:   sh_res   = val;
            REG_PERM:  sh_perm  = val[7:0];
            REG_REV:   sh_rev   = val[1:0];
            default:   sh_start = val;
        endcase
    endtask

    task automatic wait_idle();
        while (index_queue.size() > 0 || i_s_tvalid || answer_queue.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic load_config(input logic [2:0] m, input logic [2:0] r,
                               input logic [63:0] s, input logic [63:0] o,
                               input logic [7:0] p, input logic [1:0] v,
                               input logic [63:0] st);
        wait_idle();
        write_reg(REG_MODE, {61'd0, m});
        write_reg(REG_RANK, {61'd0, r});
        write_reg(REG_SRC, s);
        write_reg(REG_RES, o);
        write_reg(REG_PERM, {56'd0, p});
        write_reg(REG_REV, {62'd0, v});
        write_reg(REG_START, st);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_phases++;
    endtask

    // Random configuration, mostly consistent with the chosen mode
    task automatic random_config();
        logic [2:0]  m;
        logic [2:0]  r;
        logic [63:0] s;
        logic [63:0] o;
        logic [63:0] st;
        logic [7:0]  p;
        logic [1:0]  v;
        logic [1:0]  ax[4];
        logic [15:0] d;
        int          j;
        logic [1:0]  t;
        m  = 3'($urandom_range(0, 4));
        r  = 3'($urandom_range(1, 4));
        s  = {$urandom, $urandom};
        o  = {$urandom, $urandom};
        st = {$urandom, $urandom};
        v  = 2'($urandom_range(0, r - 1));
        for (int i = 0; i < 4; i++) ax[i] = 2'(i);
        for (int i = 3; i > 0; i--) begin
            j = int'($urandom_range(0, i));
            t = ax[i]; ax[i] = ax[j]; ax[j] = t;
        end
        if (r < 4) for (int i = 0; i < 4; i++) if (ax[i] >= r) ax[i] = 2'(i);
        for (int i = 0; i < r; i++) begin
            // shuffle restricted to used axes
        end
        for (int i = 0; i < r; i++) ax[i] = 2'(i);
        for (int i = r - 1; i > 0; i--) begin
            j = int'($urandom_range(0, i));
            t = ax[i]; ax[i] = ax[j]; ax[j] = t;
        end
        p = 8'($urandom);
        for (int i = 0; i < r; i++) p[2*i +: 2] = ax[i];
        for (int i = 0; i < r; i++) s[16*i +: 16] = 16'($urandom_range(1, 7));
        for (int i = 0; i < r; i++) begin
            d = s[16*i +: 16];
            case (m)
                MODE_IDENTITY:  o[16*i +: 16] = s[16*(r-1-i) +: 16];
                MODE_TRANSPOSE: o[16*i +: 16] = s[16*ax[i] +: 16];
                MODE_REVERSE:   o[16*i +: 16] = d;
                MODE_SLICE: begin
                    o[16*i +: 16]  = 16'($urandom_range(1, d));
                    st[16*i +: 16] = 16'($urandom_range(0, d - o[16*i +: 16]));
                end
                default:        o[16*i +: 16] = 16'(d * $urandom_range(1, 3));
            endcase
        end
        case ($urandom_range(0, 9))
            0: m = 3'($urandom_range(0, 7));
            1: r = 3'($urandom_range(0, 7));
            2: o[16*$urandom_range(0, 3) +: 16] = 16'($urandom_range(0, 9));
            3: s[16*$urandom_range(0, 3) +: 16] = 16'($urandom_range(0, 9));
            4: begin
                p = 8'($urandom);
                v = 2'($urandom);
                st[16*$urandom_range(0, 3) +: 16] = 16'($urandom_range(0, 3));
            end
            default: ;
        endcase
        load_config(m, r, s, o, p, v, st);
    endtask

    // Random indices: mostly in range, some just past the end, some anywhere
    task automatic queue_indices(input int n);
        logic [63:0] cnt;
        cnt = elem_count(sh_res, (sh_rank >= 1 && sh_rank <= 4) ? int'(sh_rank) : 1);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    add_index($urandom);
                2:       add_index(cnt[31:0] + $urandom_range(0, 2));
                default: add_index(cnt == 0 ? $urandom : 32'($urandom % cnt));
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 32'd0;
        i_m_tready  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = 3'd0;
        i_cfg_data  = 64'd0;
        n_errors = 0; n_accepted = 0; n_checked = 0; n_phases = 0;
        n_status[0] = 0; n_status[1] = 0; n_status[2] = 0;
        cycle_count = 0; quiet = 1'b0; hold_go = 1'b0;
        sh_mode = MODE_IDENTITY; sh_rank = 3'd1;
        sh_src = 64'h0001_0001_0001_0001; sh_res = 64'h0001_0001_0001_0001;
        sh_perm = 8'hE4; sh_rev = 2'd0; sh_start = 64'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset: a single element
        add_index(32'd0);
        add_index(32'd1);
        add_index(32'hFFFF_FFFF);
        // Transpose over four axes
        load_config(MODE_TRANSPOSE, 3'd4, 64'h0002_0003_0004_0005,
                    64'h0005_0002_0004_0003, 8'b10_00_01_11, 2'd0, 64'd0);
        add_index(32'd0);
        add_index(32'd119);
        add_index(32'd120);
        // Transpose with shapes that disagree still computes an index
        load_config(MODE_TRANSPOSE, 3'd2, 64'h0000_0000_FFFF_0007,
                    64'h0000_0000_0003_FFFF, 8'b00_00_00_01, 2'd0, 64'd0);
        add_index(32'd196604);
        add_index(32'd65540);
        // Reverse the outermost axis, slice, tile
        load_config(MODE_REVERSE, 3'd3, 64'h0000_0004_0003_0002,
                    64'hFFFF_0004_0003_0002, 8'hE4, 2'd0, 64'd0);
        add_index(32'd0);
        add_index(32'd23);
        load_config(MODE_SLICE, 3'd2, 64'h0000_0000_0008_0006,
                    64'h0000_0000_0003_0004, 8'hE4, 2'd1, 64'h0000_0000_0005_0002);
        add_index(32'd11);
        load_config(MODE_TILE, 3'd2, 64'h0000_0000_0003_0000,
                    64'h0000_0000_0009_0000, 8'hE4, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        add_index(32'd0);
        // Empty result axis and invalid codes
        load_config(MODE_SLICE, 3'd2, 64'h0000_0000_0004_0004,
                    64'h0000_0000_0000_0002, 8'hE4, 2'd0, 64'd0);
        add_index(32'd0);
        load_config(3'd7, 3'd1, 64'd1, 64'd1, 8'hE4, 2'd0, 64'd0);
        add_index(32'd0);
        load_config(MODE_IDENTITY, 3'd0, 64'd1, 64'd1, 8'hE4, 2'd0, 64'd0);
        add_index(32'd0);
        load_config(MODE_IDENTITY, 3'd5, 64'd1, 64'd1, 8'hE4, 2'd0, 64'd0);
        add_index(32'd0);
        // Element count above the index range, then a count near it
        load_config(MODE_IDENTITY, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        add_index(32'd5);
        load_config(MODE_IDENTITY, 3'd2, 64'h0000_0000_FFFF_FFFF,
                    64'h0000_0000_FFFF_FFFF, 8'hE4, 2'd0, 64'd0);
        add_index(32'hFFFE_0000);
        add_index(32'hFFFE_0001);
        add_index(32'hFFFF_FFFF);
        queue_indices(8);

        // Random phases; one long phase fills the pipe under a stalled receiver
        for (int ph = 0; ph < 34; ph++) begin
            random_config();
            if (ph == 6) begin
                load_config(MODE_TILE, 3'd3, 64'h0000_0002_0003_0004,
                            64'h0000_0004_0006_0008, 8'hE4, 2'd0, 64'd0);
                hold_go = 1'b1;
                queue_indices(250);
            end else begin
                if (ph == 30) quiet = 1'b1;
                queue_indices(18);
            end
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("covered %0d configurations, %0d requests, %0d results checked",
                 n_phases, n_accepted, n_checked);
        $display("status ok %0d, bad configuration %0d, out of range %0d",
                 n_status[0], n_status[1], n_status[2]);
        if (n_errors == 0 && answer_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== tensor_layout_address_generator.f =====
rtl/tlag_pkg.sv
rtl/tlag_div_step.sv
rtl/tlag_cfg.sv
rtl/tlag_coord.sv
rtl/tlag_flat.sv
rtl/tensor_layout_address_generator.sv
test/testbench.sv
